[hdl/tked_pkg.sv]
package tked_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;
	localparam logic [1:0] ST_PASS = 2'd3;

	localparam logic [4:0] K_NONE = 5'd0;
	localparam logic [4:0] K_CHAR = 5'd1;
	localparam logic [4:0] K_ENTER = 5'd2;
	localparam logic [4:0] K_TAB = 5'd3;
	localparam logic [4:0] K_SPACE = 5'd4;
	localparam logic [4:0] K_BKSP = 5'd5;
	localparam logic [4:0] K_ESC = 5'd6;
	localparam logic [4:0] K_BACKTAB = 5'd7;
	localparam logic [4:0] K_UP = 5'd8;
	localparam logic [4:0] K_DOWN = 5'd9;
	localparam logic [4:0] K_RIGHT = 5'd10;
	localparam logic [4:0] K_LEFT = 5'd11;
	localparam logic [4:0] K_HOME = 5'd12;
	localparam logic [4:0] K_END = 5'd13;
	localparam logic [4:0] K_INS = 5'd14;
	localparam logic [4:0] K_DEL = 5'd15;
	localparam logic [4:0] K_PGUP = 5'd16;
	localparam logic [4:0] K_PGDN = 5'd17;
	localparam logic [4:0] K_F1 = 5'd18;
	localparam logic [4:0] K_F2 = 5'd19;
	localparam logic [4:0] K_F3 = 5'd20;
	localparam logic [4:0] K_F4 = 5'd21;
	localparam logic [4:0] K_F5 = 5'd22;
	localparam logic [4:0] K_F6 = 5'd23;
	localparam logic [4:0] K_F7 = 5'd24;
	localparam logic [4:0] K_F8 = 5'd25;
	localparam logic [4:0] K_F9 = 5'd26;
	localparam logic [4:0] K_F10 = 5'd27;
	localparam logic [4:0] K_F11 = 5'd28;
	localparam logic [4:0] K_F12 = 5'd29;

	localparam logic [7:0] CH_FIRST_PRINT = 8'h21;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7e;

	// classified input word, front to back
	typedef struct packed {
		logic       flush;
		logic [1:0] idle_st;
		logic [4:0] idle_key;
		logic [7:0] idle_ch;
		logic       is_esc;
		logic       is_lbr;
		logic       is_ss3;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_semi;
		logic       is_final;
		logic       is_tilde;
		logic       is_z;
		logic [4:0] fin_key;
		logic [4:0] ss3_key;
	} word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] key;
		logic [2:0] mods;
		logic [7:0] ch;
		logic [7:0] len;
	} evt_t;

endpackage

[hdl/tked_front.sv]
module tked_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            opcode,
	input  logic [7:0]      data_byte,
	output logic            push,
	output tked_pkg::word_t push_word,
	input  logic            full
);
	import tked_pkg::*;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_LBR = 8'h5b;
	localparam logic [7:0] CH_O = 8'h4f;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_Z = 8'h5a;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] FINAL_LO = 8'h40;
	localparam logic [7:0] FINAL_HI = 8'h7e;

	word_t cls;
	word_t word_s1;
	logic  vld_s1;
	logic  adv;

	always_comb begin
		cls = '0;
		cls.flush = opcode;
		if (data_byte == CH_LF || data_byte == CH_CR) begin
			cls.idle_st = ST_OK;
			cls.idle_key = K_ENTER;
		end else if (data_byte == CH_TAB) begin
			cls.idle_st = ST_OK;
			cls.idle_key = K_TAB;
		end else if (data_byte == CH_SP) begin
			cls.idle_st = ST_OK;
			cls.idle_key = K_SPACE;
		end else if (data_byte == CH_BS || data_byte == CH_DEL) begin
			cls.idle_st = ST_OK;
			cls.idle_key = K_BKSP;
		end else if (data_byte[7]) begin
			cls.idle_st = ST_PASS;
			cls.idle_ch = data_byte;
		end else if (data_byte > CH_SP) begin
			cls.idle_st = ST_OK;
			cls.idle_key = K_CHAR;
			cls.idle_ch = data_byte;
		end else begin
			cls.idle_st = ST_BAD;
		end
		cls.is_esc = (data_byte == CH_ESC);
		cls.is_lbr = (data_byte == CH_LBR);
		cls.is_ss3 = (data_byte == CH_O);
		cls.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
		cls.digit = data_byte[3:0];
		cls.is_semi = (data_byte == CH_SEMI);
		cls.is_final = (data_byte >= FINAL_LO) && (data_byte <= FINAL_HI);
		cls.is_tilde = (data_byte == CH_TILDE);
		cls.is_z = (data_byte == CH_Z);
		case (data_byte)
			8'h41: cls.fin_key = K_UP;
			8'h42: cls.fin_key = K_DOWN;
			8'h43: cls.fin_key = K_RIGHT;
			8'h44: cls.fin_key = K_LEFT;
			8'h48: cls.fin_key = K_HOME;
			8'h46: cls.fin_key = K_END;
			8'h50: cls.fin_key = K_F1;
			8'h51: cls.fin_key = K_F2;
			8'h52: cls.fin_key = K_F3;
			8'h53: cls.fin_key = K_F4;
			default: cls.fin_key = K_NONE;
		endcase
		// SS3 knows no arrows
		cls.ss3_key = (cls.fin_key >= K_HOME) ? cls.fin_key : K_NONE;
	end

	assign adv = !vld_s1 || !full;
	assign req_stall = vld_s1 && full;
	assign push = vld_s1 && !full;
	assign push_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req_valid) begin
			word_s1 <= cls;
		end
	end

endmodule

[hdl/tked_fifo.sv]
module tked_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tked_pkg::word_t push_word,
	input  logic            pop,
	output tked_pkg::word_t pop_word,
	output logic            empty,
	output logic            full
);
	import tked_pkg::*;

	word_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[hdl/tked_back.sv]
module tked_back #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tked_pkg::word_t word,
	input  logic            empty,
	output logic            pop,
	output logic            evt_valid,
	input  logic            evt_stall,
	output tked_pkg::evt_t  evt
);
	import tked_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_ESC = 2'd1;
	localparam logic [1:0] MODE_CSI = 2'd2;
	localparam logic [1:0] MODE_SS3 = 2'd3;
	localparam logic [VW-1:0] VMAX = {VW{1'b1}};

	function automatic logic [4:0] tilde_key(input logic [VW-1:0] p);
		case (p)
			VW'(1), VW'(7): tilde_key = K_HOME;
			VW'(2): tilde_key = K_INS;
			VW'(3): tilde_key = K_DEL;
			VW'(4), VW'(8): tilde_key = K_END;
			VW'(5): tilde_key = K_PGUP;
			VW'(6): tilde_key = K_PGDN;
			VW'(15): tilde_key = K_F5;
			VW'(17): tilde_key = K_F6;
			VW'(18): tilde_key = K_F7;
			VW'(19): tilde_key = K_F8;
			VW'(20): tilde_key = K_F9;
			VW'(21): tilde_key = K_F10;
			VW'(23): tilde_key = K_F11;
			VW'(24): tilde_key = K_F12;
			default: tilde_key = K_NONE;
		endcase
	endfunction

	logic [1:0]    mode_q, mode_d;
	logic [VW-1:0] cur_q, cur_d;
	logic          dig_q, dig_d;
	logic [1:0]    cnt_q, cnt_d;
	logic [VW-1:0] f1_q, f1_d;
	logic [VW-1:0] f2_q, f2_d;
	logic          bad_q, bad_d;
	logic [7:0]    len_q, len_d;

	logic          evt_vld_q;
	evt_t          evt_q;
	evt_t          res;
	logic          has_res;

	logic [VW+3:0] wide;
	logic [VW-1:0] cur_inc;
	logic [7:0]    len_inc;
	logic [VW-1:0] fval;
	logic [VW-1:0] f1c, f2c;
	logic [1:0]    cntc;
	logic          empty_seq;
	logic [1:0]    fcnt;
	logic [VW-1:0] ff1, ff2;
	logic          use_mod;
	logic [VW-1:0] m;
	logic [4:0]    fkey;
	evt_t          fres;

	assign pop = !empty && (!evt_vld_q || !evt_stall);

	// parameter accumulate: x*10 + d, saturating
	assign wide = ({4'b0, cur_q} << 3) + ({4'b0, cur_q} << 1) + (VW+4)'(word.digit);
	assign cur_inc = (|wide[VW+3:VW]) ? VMAX : wide[VW-1:0];
	assign len_inc = (len_q == 8'hff) ? len_q : len_q + 8'd1;

	// close the open parameter; missing value counts as 1
	assign fval = dig_q ? cur_q : VW'(1);
	assign f1c = (cnt_q == 2'd0) ? fval : f1_q;
	assign f2c = (cnt_q == 2'd1) ? fval : f2_q;
	assign cntc = (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;

	// CSI final byte evaluation
	always_comb begin
		empty_seq = (len_inc == 8'd3);
		fcnt = empty_seq ? cnt_q : cntc;
		ff1 = empty_seq ? f1_q : f1c;
		ff2 = empty_seq ? f2_q : f2c;
		use_mod = 1'b0;
		m = VW'(1);
		if (word.is_tilde) begin
			fkey = tilde_key(ff1);
			if (fcnt >= 2'd2) begin
				use_mod = 1'b1;
				m = ff2;
			end
		end else begin
			fkey = word.fin_key;
			if (fcnt >= 2'd2) begin
				use_mod = 1'b1;
				m = ff2;
			end else if (fcnt == 2'd1 && ff1 != VW'(1)) begin
				use_mod = 1'b1;
				m = ff1;
			end
		end
		fres = '0;
		fres.len = len_inc;
		fres.status = ST_BAD;
		if (word.is_z) begin
			if (empty_seq) begin
				fres.status = ST_OK;
				fres.key = K_BACKTAB;
			end
		end else if (bad_q) begin
			fres.status = ST_BAD;
		end else if (word.is_tilde && fcnt == 2'd0) begin
			fres.status = ST_BAD;
		end else if (use_mod && (m == '0 || m > VW'(8))) begin
			fres.status = ST_BAD;
		end else if (fkey == K_NONE || fcnt == 2'd3) begin
			fres.status = ST_BAD;
		end else begin
			fres.status = ST_OK;
			fres.key = fkey;
			fres.mods = use_mod ? (m[2:0] - 3'd1) : 3'd0;
		end
	end

	always_comb begin
		mode_d = mode_q;
		cur_d = cur_q;
		dig_d = dig_q;
		cnt_d = cnt_q;
		f1_d = f1_q;
		f2_d = f2_q;
		bad_d = bad_q;
		len_d = len_q;
		res = '0;
		has_res = 1'b0;
		if (word.flush) begin
			mode_d = MODE_IDLE;
			cur_d = '0;
			dig_d = 1'b0;
			cnt_d = '0;
			f1_d = '0;
			f2_d = '0;
			bad_d = 1'b0;
			len_d = '0;
			if (mode_q == MODE_ESC) begin
				has_res = 1'b1;
				res.status = ST_OK;
				res.key = K_ESC;
				res.len = 8'd1;
			end else if (mode_q != MODE_IDLE) begin
				has_res = 1'b1;
				res.status = ST_SHORT;
				res.len = len_q;
			end
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					if (word.is_esc) begin
						mode_d = MODE_ESC;
						len_d = 8'd1;
					end else begin
						has_res = 1'b1;
						res.status = word.idle_st;
						res.key = word.idle_key;
						res.ch = word.idle_ch;
						res.len = 8'd1;
					end
				end
				MODE_ESC: begin
					if (word.is_lbr) begin
						mode_d = MODE_CSI;
						len_d = 8'd2;
					end else if (word.is_ss3) begin
						mode_d = MODE_SS3;
						len_d = 8'd2;
					end else begin
						mode_d = MODE_IDLE;
						len_d = '0;
						has_res = 1'b1;
						res.status = ST_BAD;
						res.len = 8'd2;
					end
				end
				MODE_SS3: begin
					mode_d = MODE_IDLE;
					len_d = '0;
					has_res = 1'b1;
					res.len = 8'd3;
					if (word.ss3_key == K_NONE) begin
						res.status = ST_BAD;
					end else begin
						res.status = ST_OK;
						res.key = word.ss3_key;
					end
				end
				MODE_CSI: begin
					len_d = len_inc;
					if (word.is_final) begin
						has_res = 1'b1;
						res = fres;
						mode_d = MODE_IDLE;
						cur_d = '0;
						dig_d = 1'b0;
						cnt_d = '0;
						f1_d = '0;
						f2_d = '0;
						bad_d = 1'b0;
						len_d = '0;
					end else if (word.is_digit) begin
						cur_d = cur_inc;
						dig_d = 1'b1;
					end else if (word.is_semi) begin
						f1_d = f1c;
						f2_d = f2c;
						cnt_d = cntc;
						cur_d = '0;
						dig_d = 1'b0;
					end else begin
						bad_d = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cur_q <= '0;
			dig_q <= 1'b0;
			cnt_q <= '0;
			f1_q <= '0;
			f2_q <= '0;
			bad_q <= 1'b0;
			len_q <= '0;
			evt_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				cur_q <= cur_d;
				dig_q <= dig_d;
				cnt_q <= cnt_d;
				f1_q <= f1_d;
				f2_q <= f2_d;
				bad_q <= bad_d;
				len_q <= len_d;
			end
			if (pop && has_res) begin
				evt_vld_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			evt_q <= res;
		end
	end

	assign evt_valid = evt_vld_q;
	assign evt = evt_q;

endmodule

[hdl/terminal_key_escape_decoder_unit.sv]
// channel   handshake              payload
// request   req_valid / req_stall  opcode, data_byte
// event     evt_valid / evt_stall  status, key_code, modifier_bits, char_value, sequence_length
//
// One word per cycle sustained while evt_stall is low; the parser state updates once per popped word.
// After its last word is taken, an event passes the input register, the queue write and the event register.
// A four-word queue sits between the classifier and the parser.
// evt_stall holds the event register; the queue fills, then req_stall rises.
// arst_n clears all control state; no clearing pass.
module terminal_key_escape_decoder_unit #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       opcode,
	input  logic [7:0] data_byte,
	output logic       evt_valid,
	input  logic       evt_stall,
	output logic [1:0] status,
	output logic [4:0] key_code,
	output logic [2:0] modifier_bits,
	output logic [7:0] char_value,
	output logic [7:0] sequence_length
);
	import tked_pkg::*;

	word_t push_word;
	word_t pop_word;
	evt_t  evt;
	logic  push;
	logic  pop;
	logic  empty;
	logic  full;

	tked_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	tked_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty),
		.full      (full)
	);

	tked_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (pop_word),
		.empty     (empty),
		.pop       (pop),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	assign status = evt.status;
	assign key_code = evt.key;
	assign modifier_bits = evt.mods;
	assign char_value = evt.ch;
	assign sequence_length = evt.len;

endmodule

[hdl/tked_checker.sv]
module tked_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_stall,
	input logic [1:0] status,
	input logic [4:0] key_code,
	input logic [2:0] modifier_bits,
	input logic [7:0] char_value,
	input logic [7:0] sequence_length
);
	import tked_pkg::*;

	// a held event stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid)
		else $error("event dropped while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && status != ST_OK |-> key_code == K_NONE && modifier_bits == 3'd0)
		else $error("key or modifiers on a failed word");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && status == ST_PASS |-> char_value[7] && sequence_length == 8'd1)
		else $error("bad passthrough event");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && status == ST_OK && key_code == K_CHAR |->
		sequence_length == 8'd1 && char_value >= CH_FIRST_PRINT &&
		char_value <= CH_LAST_PRINT)
		else $error("bad character event");

endmodule

bind terminal_key_escape_decoder_unit tked_checker u_tked_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt_valid),
	.evt_stall       (evt_stall),
	.status          (status),
	.key_code        (key_code),
	.modifier_bits   (modifier_bits),
	.char_value      (char_value),
	.sequence_length (sequence_length)
);
